/* src/vtisu_pkg.sv */
// Shared types and codes for the value table insert/search/update unit.
// No dependencies; used by value_table_insert_search_update_unit and its testbench.
package vtisu_pkg;

  // Request opcodes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_INSERTED    = 3'd0;
  localparam logic [2:0] STAT_FULL        = 3'd1;
  localparam logic [2:0] STAT_FOUND       = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STAT_UPDATED     = 3'd4;
  localparam logic [2:0] STAT_UPDATE_MISS = 3'd5;

  localparam logic signed [31:0] VALUE_MISS = -32'sd1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

/* src/value_table_insert_search_update_unit.sv */
// Top level of the value table: entry memory, fill count and scan sequencer.
// Depends on vtisu_pkg for opcodes, status codes and the state type.

// A request is taken when start is high and busy is low; exactly one result
// follows as a one-cycle out_valid strobe that cannot be held off. Insert and
// the unused opcode answer without a scan. Search and update walk the filled
// entries from index 0 through the entry memory's registered read port, one read per
// cycle; a scan stops at the first match (lowest index) or after the last
// filled entry, and an empty table answers without a scan.
// Entries are not cleared at reset and need no clearing pass; only entries
// below the fill count are ever compared.
module value_table_insert_search_update_unit #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_key_value,
  input  logic signed [31:0] in_new_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_result_value
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

  // Entry memory, undefined until written
  logic signed [31:0] mem [CAPACITY];

  vtisu_pkg::state_t   state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_pend_r, rd_pend_nxt;
  logic signed [31:0]  rd_data_r;
  logic                upd_r, upd_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic signed [31:0]  new_r, new_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic signed [31:0]  out_value_r, out_value_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic signed [31:0]  mem_wdata;

  logic                accept;
  logic                full;
  logic [IDX_W-1:0]    last_idx;
  logic                hit;
  logic                last;
  logic                done;

  assign accept   = start && (state_r == vtisu_pkg::ST_IDLE);
  assign full     = (fill_r == FILL_MAX);
  assign last_idx = IDX_W'(fill_r - FILL_W'(1));
  assign hit      = rd_pend_r && (rd_data_r == key_r);
  assign last     = rd_pend_r && (rd_idx_r == last_idx);
  assign done     = hit || last;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vtisu_pkg::ST_IDLE: begin
        if (accept && (in_cmd == vtisu_pkg::CMD_SEARCH || in_cmd == vtisu_pkg::CMD_UPDATE)
            && (fill_r != '0)) begin
          state_nxt = vtisu_pkg::ST_SCAN;
        end
      end
      vtisu_pkg::ST_SCAN: begin
        if (done) begin
          state_nxt = vtisu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vtisu_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory write and result for each state
  always_comb begin
    fill_nxt       = fill_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = 1'b0;
    upd_nxt        = upd_r;
    key_nxt        = key_r;
    new_nxt        = new_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_we         = 1'b0;
    mem_waddr      = IDX_W'(fill_r);
    mem_wdata      = in_key_value;
    unique case (state_r)
      vtisu_pkg::ST_IDLE: begin
        if (accept) begin
          upd_nxt      = (in_cmd == vtisu_pkg::CMD_UPDATE);
          key_nxt      = in_key_value;
          new_nxt      = in_new_value;
          scan_idx_nxt = '0;
          unique case (in_cmd)
            vtisu_pkg::CMD_INSERT: begin
              // Append or report full
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              if (full) begin
                out_status_nxt = vtisu_pkg::STAT_FULL;
              end else begin
                out_status_nxt = vtisu_pkg::STAT_INSERTED;
                mem_we         = 1'b1;
                fill_nxt       = fill_r + FILL_W'(1);
              end
            end
            vtisu_pkg::CMD_SEARCH: begin
              // Empty table misses at once
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = vtisu_pkg::STAT_NOT_FOUND;
                out_value_nxt  = vtisu_pkg::VALUE_MISS;
              end
            end
            vtisu_pkg::CMD_UPDATE: begin
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = vtisu_pkg::STAT_UPDATE_MISS;
                out_value_nxt  = '0;
              end
            end
            default: begin
              // Unused opcode: report not found with zero value
              out_valid_nxt  = 1'b1;
              out_status_nxt = vtisu_pkg::STAT_NOT_FOUND;
              out_value_nxt  = '0;
            end
          endcase
        end
      end
      vtisu_pkg::ST_SCAN: begin
        // Advance the read pointer, holding at the last filled entry
        rd_pend_nxt = !done;
        if (scan_idx_r != last_idx) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
        if (hit) begin
          out_valid_nxt = 1'b1;
          if (upd_r) begin
            out_status_nxt = vtisu_pkg::STAT_UPDATED;
            out_value_nxt  = '0;
            mem_we         = 1'b1;
            mem_waddr      = rd_idx_r;
            mem_wdata      = new_r;
          end else begin
            out_status_nxt = vtisu_pkg::STAT_FOUND;
            out_value_nxt  = key_r;
          end
        end else if (last) begin
          out_valid_nxt = 1'b1;
          if (upd_r) begin
            out_status_nxt = vtisu_pkg::STAT_UPDATE_MISS;
            out_value_nxt  = '0;
          end else begin
            out_status_nxt = vtisu_pkg::STAT_NOT_FOUND;
            out_value_nxt  = vtisu_pkg::VALUE_MISS;
          end
        end
      end
      default: begin
        rd_pend_nxt = 1'b0;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vtisu_pkg::ST_IDLE;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= scan_idx_r;
    upd_r        <= upd_nxt;
    key_r        <= key_nxt;
    new_r        <= new_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign busy             = (state_r != vtisu_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // A taken request either answers next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither answered nor scanning");

  // Fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond capacity");

  // Compared entries always lie below the fill count
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (FILL_W'(rd_idx_r) < fill_r))
    else $error("compare of an unfilled entry");

  // A result never appears in the middle of a scan that continues
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_valid_nxt) |=> !busy)
    else $error("result issued while scan continues");

endmodule

/* test/tb_value_table_insert_search_update_unit.sv */
// Testbench for the value table unit: directed and random insert, search and
// update requests checked against a shadow table. Depends on vtisu_pkg.
module tb_value_table_insert_search_update_unit;

  localparam int CAPACITY = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic signed [31:0] in_key_value;
  logic signed [31:0] in_new_value;
  logic               out_valid;
  logic [2:0]         out_status;
  logic signed [31:0] out_result_value;

  // Shadow copy of the table contents and fill count
  logic signed [31:0] shadow_entries [CAPACITY];
  int unsigned        shadow_fill;
  table_result_t      pending_results [$];
  int unsigned        fail_count;
  int unsigned        cycle_count;
  bit                 gaps_enabled;

  always #1 clk = ~clk;

  value_table_insert_search_update_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_value    (in_key_value),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_value(out_result_value)
  );

  // Lowest filled index holding key, or -1 when absent
  function automatic int first_match_index(logic signed [31:0] key);
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_entries[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the expected result
  function automatic table_result_t apply_request(logic [1:0] cmd,
                                                  logic signed [31:0] key,
                                                  logic signed [31:0] nv);
    table_result_t res;
    int            idx;
    res.status = vtisu_pkg::STAT_NOT_FOUND;
    res.value  = '0;
    case (cmd)
      vtisu_pkg::CMD_INSERT: begin
        if (shadow_fill < CAPACITY) begin
          shadow_entries[shadow_fill] = key;
          shadow_fill++;
          res.status = vtisu_pkg::STAT_INSERTED;
        end else begin
          res.status = vtisu_pkg::STAT_FULL;
        end
      end
      vtisu_pkg::CMD_SEARCH: begin
        idx = first_match_index(key);
        if (idx >= 0) begin
          res.status = vtisu_pkg::STAT_FOUND;
          res.value  = shadow_entries[idx];
        end else begin
          res.status = vtisu_pkg::STAT_NOT_FOUND;
          res.value  = vtisu_pkg::VALUE_MISS;
        end
      end
      vtisu_pkg::CMD_UPDATE: begin
        idx = first_match_index(key);
        if (idx >= 0) begin
          shadow_entries[idx] = nv;
          res.status = vtisu_pkg::STAT_UPDATED;
        end else begin
          res.status = vtisu_pkg::STAT_UPDATE_MISS;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Favor stored values and a small pool so that hits and duplicates are common
  function automatic logic signed [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50 && shadow_fill > 0) return shadow_entries[$urandom_range(0, shadow_fill - 1)];
    if (r < 75) begin
      case ($urandom_range(0, 5))
        0: return -32'sd1;
        1: return 32'sd0;
        2: return 32'sh8000_0000;
        3: return 32'sh7fff_ffff;
        default: return $urandom_range(0, 7);
      endcase
    end
    return $urandom;
  endfunction

  // Drive one request, hold it until accepted, then record its expected result
  task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] key,
                              input logic signed [31:0] nv);
    if (gaps_enabled && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_key_value <= key;
    in_new_value <= nv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(cmd, key, nv));
  endtask

  task automatic send_random_request(input int unsigned insert_pct);
    int unsigned        r;
    logic [1:0]         cmd;
    logic signed [31:0] nv;
    r = $urandom_range(0, 99);
    if (r < 3) cmd = CMD_UNUSED;
    else if (r < 3 + insert_pct) cmd = vtisu_pkg::CMD_INSERT;
    else if (r < 3 + insert_pct + (97 - insert_pct) / 2) cmd = vtisu_pkg::CMD_SEARCH;
    else cmd = vtisu_pkg::CMD_UPDATE;
    nv = ($urandom_range(0, 99) < 30) ? pick_key() : $signed($urandom);
    send_request(cmd, pick_key(), nv);
  endtask

  // Drop start and hold off until every outstanding result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd5, 32'sd0);
    send_request(vtisu_pkg::CMD_SEARCH, -32'sd1, 32'sd0);
    send_request(vtisu_pkg::CMD_UPDATE, 32'sd0, 32'sd1);
  endtask

  task automatic test_extremes();
    send_request(vtisu_pkg::CMD_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
    send_request(vtisu_pkg::CMD_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(vtisu_pkg::CMD_INSERT, -32'sd1, 32'sd0);
    send_request(vtisu_pkg::CMD_INSERT, 32'sd0, -32'sd1);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sh8000_0000, 32'sd0);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sh7fff_ffff, 32'sd0);
    // A hit on -1 returns -1 too; only the status tells it from a miss
    send_request(vtisu_pkg::CMD_SEARCH, -32'sd1, 32'sd0);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd0, 32'sd0);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd12345, 32'sd0);
  endtask

  task automatic test_duplicates();
    send_request(vtisu_pkg::CMD_INSERT, 32'sd7, 32'sd0);
    send_request(vtisu_pkg::CMD_INSERT, 32'sd7, 32'sd0);
    // Only the lowest matching entry changes
    send_request(vtisu_pkg::CMD_UPDATE, 32'sd7, 32'sd9);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd7, 32'sd0);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd9, 32'sd0);
    send_request(vtisu_pkg::CMD_UPDATE, 32'sd7, 32'sh8000_0000);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd7, 32'sd0);
    send_request(vtisu_pkg::CMD_UPDATE, 32'sh7fff_ffff, 32'sh8000_0000);
  endtask

  task automatic test_unused_cmd();
    send_request(CMD_UNUSED, -32'sd1, -32'sd1);
    send_request(vtisu_pkg::CMD_SEARCH, 32'sh8000_0000, 32'sd0);
  endtask

  task automatic test_random_fill();
    repeat (500) send_random_request(22);
  endtask

  task automatic test_table_full();
    while (shadow_fill < CAPACITY) send_request(vtisu_pkg::CMD_INSERT, pick_key(), $urandom);
    send_request(vtisu_pkg::CMD_INSERT, 32'sh7fff_ffff, 32'sd0);
    send_request(vtisu_pkg::CMD_INSERT, 32'sh8000_0000, 32'sd0);
    send_request(vtisu_pkg::CMD_INSERT, $urandom, $urandom);
    // Full-length scans on a full table
    send_request(vtisu_pkg::CMD_SEARCH, 32'sd123456789, 32'sd0);
    send_request(vtisu_pkg::CMD_UPDATE, 32'sd123456789, 32'sd1);
    wait_all_results();
  endtask

  task automatic test_random_full();
    gaps_enabled = 1'b0;
    repeat (200) send_random_request(15);
    gaps_enabled = 1'b1;
    repeat (620) send_random_request(15);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    table_result_t expected;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: status %0d value %0d", $time, out_status,
                 out_result_value);
      end else begin
        expected = pending_results.pop_front();
        if (out_status !== expected.status) begin
          fail_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   expected.status, out_status);
        end
        if (out_result_value !== expected.value) begin
          fail_count++;
          $display("%0t: result_value mismatch: expected %0d, actual %0d", $time,
                   expected.value, out_result_value);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_cmd       <= vtisu_pkg::CMD_INSERT;
    in_key_value <= '0;
    in_new_value <= '0;
    shadow_fill  = 0;
    fail_count   = 0;
    cycle_count  = 0;
    gaps_enabled = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_duplicates();
    test_unused_cmd();
    test_random_fill();
    test_table_full();
    test_random_full();

    // Drain, then let a full scan's worth of cycles pass
    wait_all_results();
    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/vtisu_pkg.sv
src/value_table_insert_search_update_unit.sv
test/tb_value_table_insert_search_update_unit.sv
